>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SIMD three-different unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/svn_pkg.sv
// ----------------------------------------------------------------------------
// svn_pkg
// Types and codes for the SIMD widening/narrowing ALU.
// ----------------------------------------------------------------------------
package svn_pkg;

    localparam logic [3:0] OP_ADDL   = 4'h0;
    localparam logic [3:0] OP_ADDW   = 4'h1;
    localparam logic [3:0] OP_SUBL   = 4'h2;
    localparam logic [3:0] OP_SUBW   = 4'h3;
    localparam logic [3:0] OP_ADDHN  = 4'h4;
    localparam logic [3:0] OP_ABAL   = 4'h5;
    localparam logic [3:0] OP_SUBHN  = 4'h6;
    localparam logic [3:0] OP_ABDL   = 4'h7;
    localparam logic [3:0] OP_MLAL   = 4'h8;
    localparam logic [3:0] OP_SQDMLAL = 4'h9;
    localparam logic [3:0] OP_MLSL   = 4'hA;
    localparam logic [3:0] OP_SQDMLSL = 4'hB;
    localparam logic [3:0] OP_MULL   = 4'hC;
    localparam logic [3:0] OP_SQDMULL = 4'hD;
    localparam logic [3:0] OP_PMULL  = 4'hE;
    localparam logic [3:0] OP_UNALLOC = 4'hF;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_DBL  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_OTHER = 2'd2;

    typedef struct packed {
        logic [63:0] left_low;
        logic [63:0] left_high;
        logic [63:0] right_low;
        logic [63:0] right_high;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic [3:0]  opcode;
        logic [1:0]  size;
        logic        unsigned_form;
        logic        upper_half;
        logic        scalar_form;
        logic        class_match;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic [1:0]  status;
    } out_item_t;

    // Classified instruction held in the queue
    typedef struct packed {
        logic [3:0]   opc;
        logic [1:0]   size;
        logic         u;
        logic         q;
        logic         sc;
        logic [1:0]   status;
        logic [127:0] left;
        logic [127:0] right;
        logic [127:0] dest;
    } entry_t;

    // Back-end first stage: registered products
    typedef struct packed {
        entry_t       e;
        logic [63:0]  nl;
        logic [63:0]  nr;
        logic [127:0] prod;
        logic [7:0]   mm;
        logic [127:0] cl;
    } s1_t;

endpackage

>>> hdl/svn_front.sv
// ----------------------------------------------------------------------------
// svn_front
// Decodes one instruction and classifies it as executed, undefined or foreign.
// ----------------------------------------------------------------------------
module svn_front (
    input  svn_pkg::in_item_t item,
    output svn_pkg::entry_t   entry
);
    import svn_pkg::*;

    logic dbl;

    always_comb
    begin
        dbl = (item.opcode == OP_SQDMLAL) || (item.opcode == OP_SQDMLSL) ||
              (item.opcode == OP_SQDMULL);
        entry.opc    = item.opcode;
        entry.size   = item.size;
        entry.u      = item.unsigned_form;
        entry.q      = item.upper_half;
        entry.sc     = item.scalar_form;
        entry.left   = {item.left_high, item.left_low};
        entry.right  = {item.right_high, item.right_low};
        entry.dest   = {item.dest_high, item.dest_low};
        if (!item.class_match)
            entry.status = ST_OTHER;
        else if (item.scalar_form && !dbl)
            entry.status = ST_UNDEF;
        else if (item.opcode == OP_PMULL && item.size == SZ_DBL)
            entry.status = (item.unsigned_form || item.scalar_form) ? ST_UNDEF : ST_DONE;
        else if (item.size == SZ_DBL || item.opcode == OP_UNALLOC ||
                 (dbl && (item.unsigned_form || item.size == SZ_BYTE)) ||
                 (item.opcode == OP_PMULL && (item.unsigned_form || item.size != SZ_BYTE)))
            entry.status = ST_UNDEF;
        else
            entry.status = ST_DONE;
    end

endmodule

>>> hdl/svn_queue.sv
// ----------------------------------------------------------------------------
// svn_queue
// Short FIFO of classified instructions between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svn_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  svn_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output svn_pkg::entry_t pop_data
);
    import svn_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_NEVER(a_q_over, clk, rst_n, count_reg > CW'(DEPTH), "queue overfilled")
    `ASSERT_CLK(a_q_inc, clk, rst_n, push && !pop |=> count_reg == CW'($past(count_reg) + 1'b1), "count did not rise")
    `ASSERT_CLK(a_q_dec, clk, rst_n, pop && !push |=> count_reg == CW'($past(count_reg) - 1'b1), "count did not fall")
    `ASSERT_CLK(a_q_hold, clk, rst_n, push == pop |=> $stable(count_reg), "count moved")

endmodule

>>> hdl/svn_back.sv
// ----------------------------------------------------------------------------
// svn_back
// Two-stage execute: lane products, then accumulate, saturate, narrow and merge.
// ----------------------------------------------------------------------------
module svn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  svn_pkg::entry_t    q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output svn_pkg::out_item_t out_data
);
    import svn_pkg::*;

    function automatic logic [63:0] msk(input logic [6:0] bits);
        return (bits >= 7'd64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic logic [63:0] ext(input logic [63:0] v, input logic [6:0] nb,
                                        input logic u);
        logic [63:0] m;
        logic [63:0] s;
        m = msk(nb);
        s = 64'd1 << (nb - 7'd1);
        return u ? (v & m) : (((v & m) ^ s) - s);
    endfunction

    function automatic logic [15:0] clmul8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
            if (b[i])
                r = r ^ ({8'd0, a} << i);
        return r;
    endfunction

    function automatic logic [63:0] sat(input logic [63:0] a, input logic [63:0] b,
                                        input logic [6:0] wb, input logic sub);
        logic [6:0]  sh;
        logic [63:0] x, y, r, ovf;
        sh  = 7'd64 - wb;
        x   = a << sh;
        y   = b << sh;
        r   = sub ? x - y : x + y;
        ovf = sub ? ((x ^ y) & (x ^ r)) : (~(x ^ y) & (x ^ r));
        if (ovf[63])
            r = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return (r >> sh) & msk(wb);
    endfunction

    function automatic logic [63:0] lane(input logic [3:0] opc, input logic u,
                                         input logic [63:0] ea, input logic [63:0] eb,
                                         input logic [63:0] acc, input logic [63:0] prod,
                                         input logic mm, input logic [6:0] nb);
        logic [6:0]  wb;
        logic [63:0] wm, v, p, sa, sb;
        wb = nb << 1;
        wm = msk(wb);
        sa = ea ^ {~u, 63'd0};
        sb = eb ^ {~u, 63'd0};
        p  = mm ? msk(wb - 7'd1) : ((prod << 1) & wm);
        case (opc)
            OP_ADDL, OP_ADDW:       v = ea + eb;
            OP_SUBL, OP_SUBW:       v = ea - eb;
            OP_ABDL:                v = (sa > sb) ? ea - eb : eb - ea;
            OP_ABAL:                v = ((sa > sb) ? ea - eb : eb - ea) + acc;
            OP_MLAL:                v = acc + prod;
            OP_MLSL:                v = acc - prod;
            OP_MULL:                v = prod;
            OP_SQDMULL:             v = p;
            OP_SQDMLAL, OP_SQDMLSL: v = sat(acc, p, wb, opc == OP_SQDMLSL);
            OP_PMULL:               v = {48'd0, clmul8(ea[7:0], eb[7:0])};
            default:                v = '0;
        endcase
        return v & wm;
    endfunction

    s1_t       s1_reg, s1_next;
    logic      s1_valid_reg;
    out_item_t out_reg, out_next;
    logic      out_valid_reg;
    logic      advance;

    assign advance   = !out_valid_reg || out_ready;
    assign q_ready   = advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Stage 1: select source halves, lane multiplies, carry-less 64x64
    always_comb
    begin
        logic signed [17:0] p0;
        logic signed [33:0] p1;
        logic signed [65:0] p2;
        logic [63:0]        ca, cb;
        logic               hi, u;
        hi = q_data.q && !q_data.sc;
        u  = q_data.u;
        s1_next.e  = q_data;
        s1_next.nl = hi ? q_data.left[127:64] : q_data.left[63:0];
        s1_next.nr = hi ? q_data.right[127:64] : q_data.right[63:0];
        s1_next.prod = '0;
        s1_next.mm   = '0;
        case (q_data.size)
            SZ_BYTE:
                for (int i = 0; i < 8; i++)
                begin
                    p0 = $signed({~u & s1_next.nl[8*i+7], s1_next.nl[8*i +: 8]}) *
                         $signed({~u & s1_next.nr[8*i+7], s1_next.nr[8*i +: 8]});
                    s1_next.prod[16*i +: 16] = p0[15:0];
                    s1_next.mm[i] = (s1_next.nl[8*i +: 8] == 8'h80) &&
                                    (s1_next.nr[8*i +: 8] == 8'h80);
                end
            SZ_HALF:
                for (int i = 0; i < 4; i++)
                begin
                    p1 = $signed({~u & s1_next.nl[16*i+15], s1_next.nl[16*i +: 16]}) *
                         $signed({~u & s1_next.nr[16*i+15], s1_next.nr[16*i +: 16]});
                    s1_next.prod[32*i +: 32] = p1[31:0];
                    s1_next.mm[i] = (s1_next.nl[16*i +: 16] == 16'h8000) &&
                                    (s1_next.nr[16*i +: 16] == 16'h8000);
                end
            SZ_WORD:
                for (int i = 0; i < 2; i++)
                begin
                    p2 = $signed({~u & s1_next.nl[32*i+31], s1_next.nl[32*i +: 32]}) *
                         $signed({~u & s1_next.nr[32*i+31], s1_next.nr[32*i +: 32]});
                    s1_next.prod[64*i +: 64] = p2[63:0];
                    s1_next.mm[i] = (s1_next.nl[32*i +: 32] == 32'h8000_0000) &&
                                    (s1_next.nr[32*i +: 32] == 32'h8000_0000);
                end
            default:
                s1_next.prod = '0;
        endcase
        ca = q_data.q ? q_data.left[127:64] : q_data.left[63:0];
        cb = q_data.q ? q_data.right[127:64] : q_data.right[63:0];
        s1_next.cl = '0;
        for (int i = 0; i < 64; i++)
            if (cb[i])
                s1_next.cl = s1_next.cl ^ ({64'd0, ca} << i);
    end

    // Stage 2: lane arithmetic, narrowing, merge
    always_comb
    begin
        logic [127:0] wres;
        logic [63:0]  nres, t, ea;
        logic [16:0]  n0;
        logic [32:0]  n1;
        logic [63:0]  n2;
        logic         wa, u, add;
        logic [3:0]   opc;
        opc  = s1_reg.e.opc;
        u    = s1_reg.e.u;
        wa   = (opc == OP_ADDW) || (opc == OP_SUBW);
        add  = opc == OP_ADDHN;
        wres = '0;
        nres = '0;
        case (s1_reg.e.size)
            SZ_BYTE:
                for (int i = 0; i < 8; i++)
                begin
                    ea = wa ? {48'd0, s1_reg.e.left[16*i +: 16]}
                            : ext({56'd0, s1_reg.nl[8*i +: 8]}, 7'd8, u);
                    t = lane(opc, u, ea, ext({56'd0, s1_reg.nr[8*i +: 8]}, 7'd8, u),
                             {48'd0, s1_reg.e.dest[16*i +: 16]},
                             {48'd0, s1_reg.prod[16*i +: 16]}, s1_reg.mm[i], 7'd8);
                    wres[16*i +: 16] = t[15:0];
                    n0 = add ? {1'b0, s1_reg.e.left[16*i +: 16]} + s1_reg.e.right[16*i +: 16]
                             : {1'b0, s1_reg.e.left[16*i +: 16]} - s1_reg.e.right[16*i +: 16];
                    n0 = n0 + (u ? 17'h80 : 17'h0);
                    nres[8*i +: 8] = n0[15:8];
                end
            SZ_HALF:
                for (int i = 0; i < 4; i++)
                begin
                    ea = wa ? {32'd0, s1_reg.e.left[32*i +: 32]}
                            : ext({48'd0, s1_reg.nl[16*i +: 16]}, 7'd16, u);
                    t = lane(opc, u, ea, ext({48'd0, s1_reg.nr[16*i +: 16]}, 7'd16, u),
                             {32'd0, s1_reg.e.dest[32*i +: 32]},
                             {32'd0, s1_reg.prod[32*i +: 32]}, s1_reg.mm[i], 7'd16);
                    wres[32*i +: 32] = t[31:0];
                    n1 = add ? {1'b0, s1_reg.e.left[32*i +: 32]} + s1_reg.e.right[32*i +: 32]
                             : {1'b0, s1_reg.e.left[32*i +: 32]} - s1_reg.e.right[32*i +: 32];
                    n1 = n1 + (u ? 33'h8000 : 33'h0);
                    nres[16*i +: 16] = n1[31:16];
                end
            SZ_WORD:
                for (int i = 0; i < 2; i++)
                begin
                    ea = wa ? s1_reg.e.left[64*i +: 64]
                            : ext({32'd0, s1_reg.nl[32*i +: 32]}, 7'd32, u);
                    t = lane(opc, u, ea, ext({32'd0, s1_reg.nr[32*i +: 32]}, 7'd32, u),
                             s1_reg.e.dest[64*i +: 64], s1_reg.prod[64*i +: 64],
                             s1_reg.mm[i], 7'd32);
                    wres[64*i +: 64] = t;
                    n2 = add ? s1_reg.e.left[64*i +: 64] + s1_reg.e.right[64*i +: 64]
                             : s1_reg.e.left[64*i +: 64] - s1_reg.e.right[64*i +: 64];
                    n2 = n2 + (u ? 64'h8000_0000 : 64'h0);
                    nres[32*i +: 32] = n2[63:32];
                end
            default:
                wres = '0;
        endcase
        if (s1_reg.e.sc)
            wres = (s1_reg.e.size == SZ_HALF) ? {96'd0, wres[31:0]} : {64'd0, wres[63:0]};

        out_next.status = s1_reg.e.status;
        if (s1_reg.e.status != ST_DONE)
            {out_next.result_high, out_next.result_low} = '0;
        else if (opc == OP_PMULL && s1_reg.e.size == SZ_DBL)
            {out_next.result_high, out_next.result_low} = s1_reg.cl;
        else if (opc == OP_ADDHN || opc == OP_SUBHN)
            {out_next.result_high, out_next.result_low} =
                s1_reg.e.q ? {nres, s1_reg.e.dest[63:0]} : {64'd0, nres};
        else
            {out_next.result_high, out_next.result_low} = wres;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            out_reg <= out_next;
        end
    end

endmodule

>>> hdl/simd_widening_narrowing_alu.sv
// ----------------------------------------------------------------------------
// simd_widening_narrowing_alu
// AdvSIMD three-different integer unit: widening, narrowing, multiply forms.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    svn_pkg::in_item_t
// out       out  out_valid/out_ready  svn_pkg::out_item_t
//
// One instruction per cycle sustained while out_ready is held high; an input
// transfer writes the queue, then the product stage register loads the entry,
// then the output register takes the result.
// The front classifies each instruction and writes it to a short queue; the
// back pulls from the queue whenever its output register is free or drained.
// An output stall backs up the back pipeline, then the queue, then in_ready.
// Reset clears only control state; no clearing pass.
// ----------------------------------------------------------------------------
module simd_widening_narrowing_alu #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  svn_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output svn_pkg::out_item_t out_data
);
    import svn_pkg::*;

    entry_t front_entry;
    entry_t q_data;
    logic   q_valid;
    logic   q_ready;

    // decode and classify (combinational, ahead of the queue)
    svn_front u_front (
        .item  (in_data),
        .entry (front_entry)
    );

    // decouples acceptance from execute stalls
    svn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // products, then accumulate/saturate/merge into output register
    svn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
